// File: rtl/fwmb_pkg.sv
// Package for the forward-window motion blur block: field widths, parameter
// defaults, sequencer state type and window control struct.
// No dependencies; the window and top-level files use it.
`default_nettype none

package fwmb_pkg;

  // Largest blur amount the window is built for
  localparam int MAX_BLUR_DEF = 31;

  // Fixed field widths
  localparam int CHAN_W = 8;
  localparam int PIX_W  = 3 * CHAN_W;
  localparam int CFG_W  = 5;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_LOAD,
    ST_ACC,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_OUT
  } state_t;

  // Window update requests from the sequencer
  typedef struct packed {
    logic push;
    logic pop;
  } win_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/fwmb_window.sv
// Pixel window of the motion blur block: circular buffer memory with head
// pointer and fill count, one registered read per cycle at head + offset.
// Depends on fwmb_pkg.
`default_nettype none

module fwmb_window #(
  parameter int DEPTH  = fwmb_pkg::MAX_BLUR_DEF + 1,
  parameter int ADDR_W = $clog2(DEPTH),
  parameter int FILL_W = $clog2(DEPTH + 1)
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire fwmb_pkg::win_ctrl_t       ctrl,
  input  wire logic [fwmb_pkg::PIX_W-1:0] push_data,
  input  wire logic [ADDR_W-1:0]         rd_index,
  output logic      [fwmb_pkg::PIX_W-1:0] rd_data,
  output logic      [FILL_W-1:0]         fill
);

  localparam logic [ADDR_W:0] DEPTH_W = (ADDR_W + 1)'(DEPTH);

  logic [fwmb_pkg::PIX_W-1:0] mem [DEPTH];
  logic [ADDR_W-1:0]          head;
  logic [ADDR_W:0]            wr_sum;
  logic [ADDR_W:0]            rd_sum;
  logic [ADDR_W-1:0]          wr_addr;
  logic [ADDR_W-1:0]          rd_addr;
  logic                       full;

  assign full = (fill == FILL_W'(DEPTH));

  // Wrap head + offset back into the buffer
  always_comb begin
    wr_sum  = {1'b0, head} + {1'b0, fill[ADDR_W-1:0]};
    rd_sum  = {1'b0, head} + {1'b0, rd_index};
    wr_addr = (wr_sum >= DEPTH_W) ? ADDR_W'(wr_sum - DEPTH_W) : wr_sum[ADDR_W-1:0];
    rd_addr = (rd_sum >= DEPTH_W) ? ADDR_W'(rd_sum - DEPTH_W) : rd_sum[ADDR_W-1:0];
  end

  // Write the pushed pixel behind the newest one; read is always registered
  always_ff @(posedge clk) begin
    if (ctrl.push && !full) begin
      mem[wr_addr] <= push_data;
    end
    rd_data <= mem[rd_addr];
  end

  // Advance head on pop, count held pixels
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      fill <= '0;
    end else if (ctrl.push && !full) begin
      fill <= fill + FILL_W'(1);
    end else if (ctrl.pop) begin
      head <= (head == ADDR_W'(DEPTH - 1)) ? '0 : head + ADDR_W'(1);
      fill <= fill - FILL_W'(1);
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(DEPTH))
    else $error("window fill above depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    ctrl.pop |-> fill != '0)
    else $error("pop from empty window");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    ctrl.pop && !ctrl.push |=> fill == $past(fill) - FILL_W'(1))
    else $error("fill did not drop after pop");

endmodule

`default_nettype wire

// File: rtl/fwmb_div.sv
// Restoring divider shared by the three color channels, one quotient bit
// per cycle. Divisor must be nonzero.
// No package dependency; instanced by the top level.
`default_nettype none

module fwmb_div #(
  parameter int NUM_W = 13,
  parameter int DEN_W = 7
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic      [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem, quot[NUM_W-1]};
    ge    = trial >= {1'b0, den_r};
    diff  = trial - {1'b0, den_r};
  end

  // Datapath: remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quot  <= num;
      den_r <= den;
    end else if (busy) begin
      rem  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quot <= {quot[NUM_W-2:0], ge};
    end
  end

  // Step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy)
    else $error("divider done without a running division");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start |=> busy && cnt == CNT_W'(NUM_W))
    else $error("divider did not start");

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    busy |-> !start)
    else $error("divider restarted while busy");

endmodule

`default_nettype wire

// File: rtl/forward_window_motion_blur_top.sv
// Forward-window motion blur: one input pixel per transfer, a pixel comes out
// once its N successors are held, or at a row end. No input is taken while
// a result is in work. Results go through one shared divider.
// Reset (rst, synchronous): window empty, blur_amount 0, no result pending.
`default_nettype none

module forward_window_motion_blur_top #(
  parameter int MAX_BLUR = fwmb_pkg::MAX_BLUR_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // Configuration write: blur_amount
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [fwmb_pkg::CFG_W-1:0]    cfg_data,
  // Input pixels
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [fwmb_pkg::PIX_W-1:0]    s_tdata,  // red, green, blue
  input  wire logic                          s_tlast,  // row_end
  // Blurred pixels
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic      [fwmb_pkg::PIX_W-1:0]    m_tdata,  // red_out, green_out, blue_out
  output logic                               m_tlast,  // row_last_out
  output logic      [0:0]                    m_tuser   // run_last
);

  localparam int DEPTH  = MAX_BLUR + 1;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int FILL_W = $clog2(DEPTH + 1);
  localparam int SUM_W  = $clog2(256 * DEPTH);
  localparam int DEN_W  = FILL_W + 1;
  localparam int CW     = fwmb_pkg::CHAN_W;

  fwmb_pkg::state_t    state;
  fwmb_pkg::state_t    state_next;
  fwmb_pkg::win_ctrl_t win_ctrl;

  logic [fwmb_pkg::CFG_W-1:0] blur_amount;
  logic [FILL_W-1:0]          n_eff;
  logic [FILL_W-1:0]          fill;
  logic [FILL_W-1:0]          fill_m1;
  logic [fwmb_pkg::PIX_W-1:0] rd_data;
  logic                       row_flag;
  logic                       emit;
  logic                       cont;
  logic [ADDR_W-1:0]          k;
  logic [ADDR_W-1:0]          idx;
  logic [DEN_W-1:0]           den;
  logic [SUM_W-1:0]           sum [3];
  logic [CW-2:0]              half [3];
  logic [1:0]                 ch;
  logic                       div_start;
  logic                       div_done;
  logic [SUM_W-1:0]           quot;
  logic [fwmb_pkg::PIX_W-1:0] out_px;
  logic                       out_row_last;
  logic                       out_run_last;
  logic [FILL_W-1:0]          k_full;

  assign cfg_ready = 1'b1;

  // Hold the blur amount
  always_ff @(posedge clk) begin
    if (rst) begin
      blur_amount <= '0;
    end else if (cfg_valid) begin
      blur_amount <= cfg_data;
    end
  end

  // Effective N, and whether the window has a pixel to emit now and after it
  always_comb begin
    n_eff   = (int'(blur_amount) > MAX_BLUR) ? FILL_W'(MAX_BLUR) : FILL_W'(blur_amount);
    fill_m1 = fill - FILL_W'(1);
    emit    = (fill > n_eff) || (row_flag && fill != '0);
    cont    = (fill_m1 > n_eff) || (row_flag && fill_m1 != '0);
    k_full  = (n_eff < fill_m1) ? n_eff : fill_m1;
  end

  fwmb_window #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W),
    .FILL_W (FILL_W)
  ) u_window (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (win_ctrl),
    .push_data (s_tdata),
    .rd_index  (idx),
    .rd_data   (rd_data),
    .fill      (fill)
  );

  fwmb_div #(
    .NUM_W (SUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (sum[ch]),
    .den   (den),
    .done  (div_done),
    .quot  (quot)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      fwmb_pkg::ST_IDLE: begin
        if (s_tvalid) state_next = fwmb_pkg::ST_CHECK;
      end
      fwmb_pkg::ST_CHECK: begin
        state_next = emit ? fwmb_pkg::ST_LOAD : fwmb_pkg::ST_IDLE;
      end
      fwmb_pkg::ST_LOAD: begin
        state_next = fwmb_pkg::ST_ACC;
      end
      fwmb_pkg::ST_ACC: begin
        state_next = (idx == k) ? fwmb_pkg::ST_DIV_START : fwmb_pkg::ST_LOAD;
      end
      fwmb_pkg::ST_DIV_START: begin
        state_next = fwmb_pkg::ST_DIV_WAIT;
      end
      fwmb_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          state_next = (ch == 2'd2) ? fwmb_pkg::ST_OUT : fwmb_pkg::ST_DIV_START;
        end
      end
      fwmb_pkg::ST_OUT: begin
        if (m_tready) state_next = fwmb_pkg::ST_CHECK;
      end
      default: state_next = fwmb_pkg::ST_IDLE;
    endcase
  end

  // Handshake and unit control
  always_comb begin
    s_tready      = (state == fwmb_pkg::ST_IDLE);
    m_tvalid      = (state == fwmb_pkg::ST_OUT);
    win_ctrl.push = (state == fwmb_pkg::ST_IDLE) && s_tvalid;
    win_ctrl.pop  = (state == fwmb_pkg::ST_OUT) && m_tready;
    div_start     = (state == fwmb_pkg::ST_DIV_START);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fwmb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath: latch row flag, sum the window, collect quotients
  always_ff @(posedge clk) begin
    case (state)
      fwmb_pkg::ST_IDLE: begin
        if (s_tvalid) row_flag <= s_tlast;
      end
      fwmb_pkg::ST_CHECK: begin
        k            <= k_full[ADDR_W-1:0];
        den          <= {k_full + FILL_W'(1), 1'b0};
        idx          <= '0;
        ch           <= '0;
        out_run_last <= !cont;
        out_row_last <= row_flag && fill_m1 == '0;
      end
      fwmb_pkg::ST_ACC: begin
        for (int c = 0; c < 3; c++) begin
          if (idx == '0) begin
            half[c] <= rd_data[c*CW+1 +: CW-1];
            sum[c]  <= SUM_W'(rd_data[c*CW+1 +: CW-1]);
          end else begin
            sum[c] <= sum[c] + SUM_W'(rd_data[c*CW +: CW]);
          end
        end
        if (idx != k) idx <= idx + ADDR_W'(1);
      end
      fwmb_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          out_px[ch*CW +: CW] <= CW'(SUM_W'(half[ch]) + quot);
          ch <= ch + 2'd1;
        end
      end
      default: begin
      end
    endcase
  end

  assign m_tdata    = out_px;
  assign m_tlast    = out_row_last;
  assign m_tuser[0] = out_run_last;

  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while a pixel is in work");

  a_out_blocks_in: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("input ready while a result is pending");

  a_run_end_idle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tuser[0] |-> ##2 s_tready)
    else $error("block did not return to idle after the last result");

  a_row_last_run_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser[0])
    else $error("row end result is not the last of its run");

endmodule

`default_nettype wire
